// ===== hdl/gf256_arith_unit_macros.svh =====
// ---------------------------------------------------------------------------
// gf256_arith_unit_macros
// assertion macros shared by the gf(2^8) arithmetic unit
// ---------------------------------------------------------------------------
`ifndef GF256_ARITH_UNIT_MACROS_SVH
`define GF256_ARITH_UNIT_MACROS_SVH

// same-cycle implication
`define GFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gfa_pkg.sv =====
// ---------------------------------------------------------------------------
// gfa_pkg
// types, codes, field multiply and microprogram of the gf(2^8) unit
// ---------------------------------------------------------------------------
package gfa_pkg;

  localparam int unsigned UcDepth = 17;
  localparam int unsigned PcW     = $clog2(UcDepth);

  typedef enum logic [1:0] {
    OPC_MUL   = 2'd0,
    OPC_INV   = 2'd1,
    OPC_SOLVE = 2'd2,
    OPC_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSOL = 2'd1,
    ST_ALL   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ALU_MULAB,
    ALU_LDA,
    ALU_SQR,
    ALU_MULA,
    ALU_MULB,
    ALU_CLR
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_SEQ,
    BR_END,
    BR_END_IF_INV
  } branch_t;

  typedef struct packed {
    alu_op_t alu;
    branch_t br;
  } uword_t;

  typedef struct packed {
    alu_op_t alu;
    logic    en;
    logic    last;
  } ctrl_t;

  localparam logic [PcW-1:0] EntryMul  = PcW'(0);
  localparam logic [PcW-1:0] EntryInv  = PcW'(1);
  localparam logic [PcW-1:0] EntryNone = PcW'(16);

  localparam logic [7:0] PolyLow = 8'h1b;
  localparam logic [7:0] HighBit = 8'h80;

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] xs;
    acc = 8'h00;
    xs  = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc = acc ^ xs;
      xs = ((xs & HighBit) != 8'h00) ? ((xs << 1) ^ PolyLow) : (xs << 1);
    end
    return acc;
  endfunction

  // a^254: load a, six rounds of square and multiply by a, final square
  function automatic uword_t ucode(input logic [PcW-1:0] addr);
    uword_t w;
    case (addr)
      PcW'(0):  w = '{alu: ALU_MULAB, br: BR_END};
      PcW'(1):  w = '{alu: ALU_LDA,   br: BR_SEQ};
      PcW'(2),  PcW'(4),  PcW'(6),
      PcW'(8),  PcW'(10), PcW'(12):
                w = '{alu: ALU_SQR,   br: BR_SEQ};
      PcW'(3),  PcW'(5),  PcW'(7),
      PcW'(9),  PcW'(11), PcW'(13):
                w = '{alu: ALU_MULA,  br: BR_SEQ};
      PcW'(14): w = '{alu: ALU_SQR,   br: BR_END_IF_INV};
      PcW'(15): w = '{alu: ALU_MULB,  br: BR_END};
      default:  w = '{alu: ALU_CLR,   br: BR_END};
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry_addr(input opcode_t op);
    logic [PcW-1:0] e;
    unique case (op)
      OPC_MUL:   e = EntryMul;
      OPC_INV:   e = EntryInv;
      OPC_SOLVE: e = EntryInv;
      default:   e = EntryNone;
    endcase
    return e;
  endfunction

  function automatic status_t status_of(input opcode_t op, input logic [7:0] a,
                                        input logic [7:0] b);
    status_t s;
    s = ST_OK;
    if (a == 8'h00) begin
      if (op == OPC_INV) s = ST_NOSOL;
      else if (op == OPC_SOLVE) s = (b == 8'h00) ? ST_ALL : ST_NOSOL;
    end
    return s;
  endfunction

endpackage

// ===== hdl/gfa_seq.sv =====
// ---------------------------------------------------------------------------
// gfa_seq
// step counter and microprogram rom, emits one control word per step
// ---------------------------------------------------------------------------
module gfa_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  gfa_pkg::opcode_t opcode,
  input  logic            hold,
  output logic            busy,
  output gfa_pkg::ctrl_t  ctrl
);
  import gfa_pkg::*;

  logic [PcW-1:0] pc_r, pc_nxt;
  logic           run_r, run_nxt;
  logic           inv_r, inv_nxt;
  uword_t         uw;
  logic           last;

  always_comb begin
    uw        = ucode(pc_r);
    last      = (uw.br == BR_END) || ((uw.br == BR_END_IF_INV) && inv_r);
    ctrl.alu  = uw.alu;
    ctrl.last = last;
    ctrl.en   = run_r && !(last && hold);
  end

  always_comb begin
    pc_nxt  = pc_r;
    run_nxt = run_r;
    inv_nxt = inv_r;
    if (start) begin
      pc_nxt  = entry_addr(opcode);
      run_nxt = 1'b1;
      inv_nxt = (opcode == OPC_INV);
    end else if (ctrl.en) begin
      if (last) run_nxt = 1'b0;
      else pc_nxt = PcW'(pc_r + PcW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      run_r <= 1'b0;
      inv_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      run_r <= run_nxt;
      inv_r <= inv_nxt;
    end
  end

  assign busy = run_r;

endmodule

// ===== hdl/gfa_dpath.sv =====
// ---------------------------------------------------------------------------
// gfa_dpath
// operand and accumulator registers around one shared field multiplier
// ---------------------------------------------------------------------------
module gfa_dpath (
  input  logic             clk,
  input  logic             load,
  input  gfa_pkg::opcode_t opcode,
  input  logic [7:0]       operand_a,
  input  logic [7:0]       operand_b,
  input  gfa_pkg::ctrl_t   ctrl,
  output logic [7:0]       acc_nxt_o,
  output gfa_pkg::status_t status_o
);
  import gfa_pkg::*;

  logic [7:0] a_r, b_r, acc_r, acc_nxt;
  status_t    status_r;
  logic [7:0] mx, my, prod;

  always_comb begin
    mx = acc_r;
    my = acc_r;
    unique case (ctrl.alu)
      ALU_MULAB: begin mx = a_r; my = b_r; end
      ALU_MULA:  my = a_r;
      ALU_MULB:  my = b_r;
      default:   my = acc_r;
    endcase
    prod = gf_mul(mx, my);
    unique case (ctrl.alu)
      ALU_LDA: acc_nxt = a_r;
      ALU_CLR: acc_nxt = 8'h00;
      default: acc_nxt = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r      <= operand_a;
      b_r      <= operand_b;
      status_r <= status_of(opcode, operand_a, operand_b);
    end
    if (ctrl.en) acc_r <= acc_nxt;
  end

  assign acc_nxt_o = acc_nxt;
  assign status_o  = status_r;

endmodule

// ===== hdl/gf256_arith_unit.sv =====
// ---------------------------------------------------------------------------
// gf256_arith_unit
// gf(2^8) multiply, inverse and solve under the aes polynomial, microcoded
// ---------------------------------------------------------------------------
// channel  direction  ports
// in       in         in_valid, in_stall, in_opcode, in_operand_a, in_operand_b
// out      out        out_valid, out_stall, out_result_byte, out_status
//
// microprogram steps per word: multiply 1, inverse 14, solve 15, unused code 1
// one step per cycle on the single multiplier; result registered after the last step
// in_stall is high while a program runs; a waiting result does not block input
// the last step waits while the output register is full and stalled
// synchronous active-low reset clears sequencer and output valid
module gf256_arith_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_result_byte,
  output logic [1:0] out_status
);
  import gfa_pkg::*;

  `include "gf256_arith_unit_macros.svh"

  logic       busy, accept, hold, done;
  ctrl_t      ctrl;
  opcode_t    opc;
  logic [7:0] acc_nxt;
  status_t    status;
  logic       fail_out;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_result_byte_r, out_result_byte_nxt;
  status_t    out_status_r, out_status_nxt;

  assign opc      = opcode_t'(in_opcode);
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign hold     = out_valid_r && out_stall;
  assign done     = ctrl.en && ctrl.last;

  gfa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .opcode (opc),
    .hold   (hold),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  gfa_dpath u_dpath (
    .clk       (clk),
    .load      (accept),
    .opcode    (opc),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .ctrl      (ctrl),
    .acc_nxt_o (acc_nxt),
    .status_o  (status)
  );

  always_comb begin
    out_valid_nxt       = out_valid_r;
    out_result_byte_nxt = out_result_byte_r;
    out_status_nxt      = out_status_r;
    if (done) begin
      out_valid_nxt       = 1'b1;
      out_result_byte_nxt = acc_nxt;
      out_status_nxt      = status;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_result_byte_r <= out_result_byte_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_result_byte_r;
  assign out_status      = out_status_r;

  assign fail_out = out_valid && (out_status != ST_OK);

  `GFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, in_stall, "program not started")
  `GFA_ASSERT_NOW(a_fail_zero, clk, rst_n, fail_out, out_result_byte == '0, "error word not zero")
  `GFA_ASSERT_NOW(a_no_overrun, clk, rst_n, done, !hold, "stalled result overwritten")

endmodule
